>>> rtl/alrc_pkg.sv
`default_nettype none

package alrc_pkg;

    // Field widths
    localparam int LATENCY_W = 16;
    localparam int TARGET_W  = 10;
    localparam int INTEG_W   = 13;
    localparam int OFFSET_W  = 16;
    localparam int GAP_W     = 18;
    localparam int MAG_W     = 17;
    localparam int K_W       = 7;
    localparam int STEP_W    = 14;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_OFF = 2'd1;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 10'd60;

    // Control law constants; gap bands are in 1/16 ms
    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 13'sd3600;
    localparam logic [MAG_W-1:0]          DEAD_BAND   = 17'd48;
    localparam logic [MAG_W-1:0]          NEAR_BAND   = 17'd16;
    // At and above this magnitude the step reaches its cap (k >= 80)
    localparam logic [MAG_W-1:0]          CAP_MAG     = 17'd207;
    localparam logic [STEP_W-1:0]         STEP_UNIT   = 14'd180;
    localparam logic [STEP_W-1:0]         STEP_CAP    = 14'd14400;

    typedef logic [LATENCY_W-1:0]        latency_t;
    typedef logic [TARGET_W-1:0]         target_t;
    typedef logic signed [INTEG_W-1:0]   integ_t;
    typedef logic signed [OFFSET_W-1:0]  offset_t;

    typedef struct packed {
        latency_t avg_latency;
        logic     recording;
        logic     normal_speed;
    } item_t;

    typedef struct packed {
        target_t target_latency_ms;
        logic    dynamic_rate_off;
    } cfg_t;

    typedef struct packed {
        integ_t  integ;
        offset_t offset;
    } ctl_state_t;

endpackage

`default_nettype wire

>>> rtl/alrc_if.sv
`default_nettype none

// Tick request channel
interface alrc_in_if;
    logic               valid;
    logic               ready;
    alrc_pkg::latency_t avg_latency;
    logic               recording;
    logic               normal_speed;

    modport source (output valid, output avg_latency, output recording,
                    output normal_speed, input ready);
    modport sink (input valid, input avg_latency, input recording,
                  input normal_speed, output ready);
endinterface

// Result request channel
interface alrc_out_if;
    logic              valid;
    logic              ready;
    alrc_pkg::offset_t rate_offset;
    alrc_pkg::integ_t  under_count;

    modport source (output valid, output rate_offset, output under_count, input ready);
    modport sink (input valid, input rate_offset, input under_count, output ready);
endinterface

`default_nettype wire

>>> rtl/alrc_step_calc.sv
`default_nettype none

// Next integrator and offset for one tick, given the current state.
module alrc_step_calc (
    input  wire alrc_pkg::cfg_t       cfg,
    input  wire alrc_pkg::item_t      item,
    input  wire alrc_pkg::ctl_state_t cur,
    output alrc_pkg::ctl_state_t      nxt
);

    logic signed [alrc_pkg::GAP_W-1:0] gap;
    logic signed [alrc_pkg::GAP_W-1:0] neg_gap;
    logic [alrc_pkg::MAG_W-1:0]        mag;
    logic [alrc_pkg::MAG_W-1:0]        excess;
    logic [alrc_pkg::K_W-1:0]          k;
    logic [alrc_pkg::STEP_W-1:0]       step;
    logic                              clear;
    logic                              gap_neg;
    logic                              gap_pos;
    alrc_pkg::integ_t                  integ_next;
    alrc_pkg::offset_t                 integ_wide;
    alrc_pkg::offset_t                 step_wide;

    always_comb
    begin
        clear = cfg.dynamic_rate_off || item.recording || !item.normal_speed
                || (item.avg_latency == '0);

        gap     = $signed({2'b00, item.avg_latency})
                  - $signed({4'b0000, cfg.target_latency_ms, 4'b0000});
        neg_gap = -gap;
        gap_neg = gap[alrc_pkg::GAP_W-1];
        gap_pos = !gap_neg && (gap != '0);
        mag     = gap_neg ? neg_gap[alrc_pkg::MAG_W-1:0] : gap[alrc_pkg::MAG_W-1:0];

        // k = ceil((mag - 48) / 2), only used below the cap where it fits 7 bits
        excess = mag - (alrc_pkg::DEAD_BAND - 17'd1);
        k      = excess[alrc_pkg::K_W:1];
        if (mag >= alrc_pkg::CAP_MAG)
        begin
            step = alrc_pkg::STEP_CAP;
        end
        else
        begin
            step = {{(alrc_pkg::STEP_W-alrc_pkg::K_W){1'b0}}, k} * alrc_pkg::STEP_UNIT;
        end

        integ_next = cur.integ;
        if (gap_neg && (cur.integ < alrc_pkg::INTEG_LIMIT))
        begin
            integ_next = cur.integ + 13'sd1;
        end
        else if (gap_pos && (cur.integ > -alrc_pkg::INTEG_LIMIT))
        begin
            integ_next = cur.integ - 13'sd1;
        end

        integ_wide = {{(alrc_pkg::OFFSET_W-alrc_pkg::INTEG_W){integ_next[alrc_pkg::INTEG_W-1]}},
                      integ_next};
        step_wide  = $signed({{(alrc_pkg::OFFSET_W-alrc_pkg::STEP_W){1'b0}}, step});

        nxt.integ  = integ_next;
        nxt.offset = cur.offset;
        if (clear)
        begin
            nxt.integ  = '0;
            nxt.offset = '0;
        end
        else if (mag > alrc_pkg::DEAD_BAND)
        begin
            nxt.offset = gap_pos ? (integ_wide - step_wide) : (integ_wide + step_wide);
        end
        else if (mag < alrc_pkg::NEAR_BAND)
        begin
            nxt.offset = integ_wide;
        end
    end

endmodule

`default_nettype wire

>>> rtl/audio_latency_rate_controller.sv
// An accepted tick request moves from the input register into the output register once
// that register is free or being emptied, and the sink takes its result from there. Throughput:
// one tick per cycle while the sink keeps up; the only loop is the integrator/offset update.
// A full output register and a stalled sink back-pressure the input stage, one stage at a time.
// Reset (rst_n, asynchronous, active low) empties both stages, zeroes the integrator and offset,
// and sets the target latency to 60 ms with dynamic rate control enabled.
`default_nettype none

module audio_latency_rate_controller (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire [alrc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [alrc_pkg::CFG_DATA_W-1:0]       cfg_data,
    alrc_in_if.sink                              in_ch,
    alrc_out_if.source                           out_ch
);

    // Configuration registers. They must only be written while the block is idle (the block
    // itself does not enforce this), so the compute stage may read them directly.
    alrc_pkg::target_t target_reg;
    logic              rate_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= alrc_pkg::TARGET_RESET;
            rate_off_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                alrc_pkg::REG_TARGET:
                begin
                    target_reg <= cfg_data[alrc_pkg::TARGET_W-1:0];
                end
                alrc_pkg::REG_RATE_OFF:
                begin
                    rate_off_reg <= cfg_data[0];
                end
                default:
                begin
                    // Indexes beyond the register list are ignored.
                end
            endcase
        end
    end

    // Output register: holds a finished result until the sink takes it.
    logic              out_valid_reg;
    alrc_pkg::offset_t out_offset_reg;
    alrc_pkg::integ_t  out_integ_reg;

    // Input register. It is refilled whenever its content moves on to the output
    // register in the same cycle, so one request per cycle is taken while the output side moves.
    logic              s1_valid_reg;
    alrc_pkg::item_t   s1_item_reg;
    logic              s1_adv;
    logic              in_fire;

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.avg_latency  <= in_ch.avg_latency;
            s1_item_reg.recording    <= in_ch.recording;
            s1_item_reg.normal_speed <= in_ch.normal_speed;
        end
    end

    // Controller state: the integrator and the current offset. It advances exactly when a
    // request leaves the input register, so consecutive requests see each other's updates.
    alrc_pkg::ctl_state_t state_reg;
    alrc_pkg::ctl_state_t state_next;
    alrc_pkg::cfg_t       cfg_cur;

    assign cfg_cur.target_latency_ms = target_reg;
    assign cfg_cur.dynamic_rate_off  = rate_off_reg;

    alrc_step_calc u_step_calc (
        .cfg  (cfg_cur),
        .item (s1_item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_adv)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_offset_reg <= state_next.offset;
            out_integ_reg  <= state_next.integ;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.rate_offset = out_offset_reg;
    assign out_ch.under_count = out_integ_reg;

endmodule

`default_nettype wire

>>> rtl/alrc_checker.sv
`default_nettype none

module alrc_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    out_valid,
    input wire                    out_ready,
    input wire alrc_pkg::offset_t rate_offset,
    input wire alrc_pkg::integ_t  under_count
);

    logic             out_fire;
    alrc_pkg::integ_t last_count_reg;
    alrc_pkg::integ_t count_delta;

    assign out_fire    = out_valid && out_ready;
    assign count_delta = under_count - last_count_reg;

    // Integrator value of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
        end
        else if (out_fire)
        begin
            last_count_reg <= under_count;
        end
    end

    // The integrator moves by at most one per tick, or is cleared.
    a_integ_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (under_count == '0) || (count_delta == 13'sd0)
                     || (count_delta == 13'sd1) || (count_delta == -13'sd1))
        else $error("integrator jumped by more than one between results");

    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (under_count <= 13'sd3600) && (under_count >= -13'sd3600))
        else $error("integrator outside its saturation limits");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rate_offset <= 16'sd18000) && (rate_offset >= -16'sd18000))
        else $error("rate offset outside its range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rate_offset)
                                    && $stable(under_count))
        else $error("stalled result changed");

endmodule

bind audio_latency_rate_controller alrc_checker u_alrc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .rate_offset (out_ch.rate_offset),
    .under_count (out_ch.under_count)
);

`default_nettype wire

>>> test/audio_latency_rate_controller_tb.sv
`timescale 1ns / 100ps

module audio_latency_rate_controller_tb;

    // Register indexes beyond the list; writes to them must change nothing.
    localparam logic [alrc_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [alrc_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    // Cycles without any accepted request on either channel before the run is abandoned.
    // The slowest correct spacing is the longest drawn sender gap plus the longest drawn
    // receiver stall plus the two-stage pipeline, so this is many times the worst case.
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        alrc_pkg::offset_t rate_offset;
        alrc_pkg::integ_t  under_count;
    } rate_result_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [alrc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [alrc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    alrc_in_if  tick_ch ();
    alrc_out_if rate_ch ();

    audio_latency_rate_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (tick_ch),
        .out_ch    (rate_ch)
    );

    // Tick requests waiting to be driven, and the rate results that accepted ticks
    // have earned but which have not yet come out of the block.
    alrc_pkg::item_t ticks_to_send[$];
    rate_result_t    rate_results_due[$];

    // Our own copy of the registers and of the controller state.
    alrc_pkg::target_t target_shadow = alrc_pkg::TARGET_RESET;
    logic              rate_off_shadow = 1'b0;
    alrc_pkg::integ_t  integ_model = '0;
    alrc_pkg::offset_t offset_model = '0;

    // When set, the matching side of the link never idles, giving back-to-back stretches.
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    int              mismatch_count = 0;
    int              quiet_cycles = 0;
    int              send_wait = 0;
    int              take_wait = 0;
    alrc_pkg::item_t sent_tick;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int draw_wait(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 11));
    endfunction

    // Advances the controller by one tick and records the result it must produce.
    // The gap is worked out in 1/16 ms, as the block does, so that every band edge is exact.
    function automatic void predict_rate_update(input alrc_pkg::item_t t);
        logic signed [alrc_pkg::GAP_W-1:0] gap;
        logic [alrc_pkg::MAG_W-1:0]        mag;
        int                                step;
        if (rate_off_shadow || t.recording || !t.normal_speed || t.avg_latency == '0)
        begin
            integ_model = '0;
            offset_model = '0;
        end
        else
        begin
            gap = $signed({2'b00, t.avg_latency}) - $signed({4'b0000, target_shadow, 4'b0000});
            mag = (gap < 0) ? alrc_pkg::MAG_W'(-gap) : alrc_pkg::MAG_W'(gap);

            // The integrator counts ticks under the target up and ticks over it down,
            // and stops at its limits rather than wrapping.
            if (gap < 0 && integ_model < alrc_pkg::INTEG_LIMIT)
            begin
                integ_model = integ_model + 13'sd1;
            end
            else if (gap > 0 && integ_model > -alrc_pkg::INTEG_LIMIT)
            begin
                integ_model = integ_model - 13'sd1;
            end

            // Outside the dead band a proportional step is added under the target and subtracted over
            // it, rounding the excess half-sixteenths up; within the near band only the integrator term
            // remains; in between the previous offset is held.
            if (mag > alrc_pkg::DEAD_BAND)
            begin
                step = (int'(mag) - int'(alrc_pkg::DEAD_BAND) + 1) / 2
                       * int'(alrc_pkg::STEP_UNIT);
                if (step > int'(alrc_pkg::STEP_CAP))
                begin
                    step = int'(alrc_pkg::STEP_CAP);
                end
                offset_model = alrc_pkg::offset_t'((gap > 0) ? int'(integ_model) - step
                                                             : int'(integ_model) + step);
            end
            else if (mag < alrc_pkg::NEAR_BAND)
            begin
                offset_model = alrc_pkg::offset_t'(int'(integ_model));
            end
        end
        rate_results_due.push_back('{offset_model, integ_model});
    endfunction

    // Driver: presents queued tick requests, holds each until it is taken, and then
    // leaves the randomly drawn number of idle cycles before the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
            tick_ch.avg_latency <= '0;
            tick_ch.recording <= 1'b0;
            tick_ch.normal_speed <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                predict_rate_update(sent_tick);
            end
            if (!tick_ch.valid || tick_ch.ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait = send_wait - 1;
                    tick_ch.valid <= 1'b0;
                end
                else if (ticks_to_send.size() != 0)
                begin
                    sent_tick = ticks_to_send.pop_front();
                    tick_ch.valid <= 1'b1;
                    tick_ch.avg_latency <= sent_tick.avg_latency;
                    tick_ch.recording <= sent_tick.recording;
                    tick_ch.normal_speed <= sent_tick.normal_speed;
                    send_wait = draw_wait(send_steady);
                end
                else
                begin
                    tick_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes result requests, checks each against the oldest prediction, and
    // stalls for a freshly drawn number of cycles after every one it accepts.
    always @(posedge clk or negedge rst_n)
    begin
        rate_result_t due;
        if (!rst_n)
        begin
            rate_ch.ready <= 1'b0;
            take_wait = 0;
        end
        else
        begin
            if (rate_ch.valid && rate_ch.ready)
            begin
                if (rate_results_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result offset %0d count %0d",
                                              rate_ch.rate_offset, rate_ch.under_count));
                end
                else
                begin
                    due = rate_results_due.pop_front();
                    if (rate_ch.rate_offset !== due.rate_offset)
                    begin
                        report_mismatch($sformatf("rate_offset %0d, expected %0d",
                                                  rate_ch.rate_offset, due.rate_offset));
                    end
                    if (rate_ch.under_count !== due.under_count)
                    begin
                        report_mismatch($sformatf("under_count %0d, expected %0d",
                                                  rate_ch.under_count, due.under_count));
                    end
                end
                take_wait = draw_wait(take_steady);
            end
            else if (take_wait != 0)
            begin
                take_wait = take_wait - 1;
            end
            rate_ch.ready <= (take_wait == 0);
        end
    end

    // Watchdog: a block that stops moving requests ends the run as a failure.
    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (rate_ch.valid && rate_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_tick(input alrc_pkg::latency_t avg, input logic rec,
                              input logic normal);
        alrc_pkg::item_t t;
        t.avg_latency = avg;
        t.recording = rec;
        t.normal_speed = normal;
        ticks_to_send.push_back(t);
    endtask

    // Waits until nothing is queued, nothing is on the input channel and every
    // predicted result has been seen. Since each tick yields exactly one result,
    // the block is then idle and its registers may be rewritten.
    task automatic wait_drained();
        @(negedge clk);
        while (ticks_to_send.size() != 0 || tick_ch.valid || rate_results_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [alrc_pkg::CFG_INDEX_W-1:0] index,
                             input logic [alrc_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == alrc_pkg::REG_TARGET)
        begin
            target_shadow = value;
        end
        else if (index == alrc_pkg::REG_RATE_OFF)
        begin
            rate_off_shadow = value[0];
        end
    endtask

    task automatic finish_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // A well-formed tick whose latency lands in one of the control bands around the
    // current target, so that the integrator and the offset really get exercised.
    task automatic queue_shaped_tick();
        int centre;
        int delta;
        int band;
        int avg;
        centre = int'(target_shadow) * 16;
        band = $urandom_range(0, 3);
        case (band)
            0: delta = int'($urandom_range(0, 30)) - 15;
            1: delta = int'($urandom_range(16, 48));
            2: delta = int'($urandom_range(49, 260));
            default: delta = int'($urandom_range(1, 4000));
        endcase
        if (band != 0 && $urandom_range(0, 1) == 0)
        begin
            delta = -delta;
        end
        avg = centre + delta;
        if (avg < 1 || avg > 65535)
        begin
            avg = $urandom_range(1, 65535);
        end
        queue_tick(alrc_pkg::latency_t'(avg), 1'b0, 1'b1);
    endtask

    // Noise: any latency, with the recording and speed flags at random.
    task automatic queue_noise_tick();
        alrc_pkg::latency_t avg;
        avg = ($urandom_range(0, 7) == 0) ? alrc_pkg::latency_t'(0)
                                          : alrc_pkg::latency_t'($urandom_range(0, 65535));
        queue_tick(avg, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        logic [alrc_pkg::CFG_DATA_W-1:0] data;
        int                              pick;

        tick_ch.valid = 1'b0;
        tick_ch.avg_latency = '0;
        tick_ch.recording = 1'b0;
        tick_ch.normal_speed = 1'b0;
        rate_ch.ready = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, target 60 ms, which is 960 sixteenths. The ticks walk the
        // band edges: on target, the near band, the hold band, just outside the dead
        // band on either side, the first two step sizes, the last step below the cap
        // and the cap itself, then the latency extremes and each clear condition.
        queue_tick(16'd960, 1'b0, 1'b1);
        queue_tick(16'd961, 1'b0, 1'b1);
        queue_tick(16'd945, 1'b0, 1'b1);
        queue_tick(16'd944, 1'b0, 1'b1);
        queue_tick(16'd912, 1'b0, 1'b1);
        queue_tick(16'd911, 1'b0, 1'b1);
        queue_tick(16'd1009, 1'b0, 1'b1);
        queue_tick(16'd1010, 1'b0, 1'b1);
        queue_tick(16'd1011, 1'b0, 1'b1);
        queue_tick(16'd1166, 1'b0, 1'b1);
        queue_tick(16'd1167, 1'b0, 1'b1);
        queue_tick(16'hFFFF, 1'b0, 1'b1);
        queue_tick(16'h0001, 1'b0, 1'b1);
        queue_tick(16'h0000, 1'b0, 1'b1);
        queue_tick(16'd1200, 1'b1, 1'b1);
        queue_tick(16'd1200, 1'b0, 1'b0);
        queue_tick(16'd1200, 1'b1, 1'b0);
        wait_drained();

        // Smallest target. The spare register indexes are written with all ones, and
        // the rate-off register with its high bits set but its enable bit clear, none
        // of which may change anything.
        write_reg(alrc_pkg::REG_TARGET, '0);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        write_reg(alrc_pkg::REG_RATE_OFF, 10'h3FE);
        finish_writes();
        queue_tick(16'h0000, 1'b0, 1'b1);
        queue_tick(16'h0001, 1'b0, 1'b1);
        queue_tick(16'd49, 1'b0, 1'b1);
        queue_tick(16'hFFFF, 1'b0, 1'b1);
        wait_drained();

        // Largest target.
        write_reg(alrc_pkg::REG_TARGET, '1);
        finish_writes();
        queue_tick(16'hFFFF, 1'b0, 1'b1);
        queue_tick(16'h0001, 1'b0, 1'b1);
        wait_drained();

        // Dynamic rate control switched off: every tick clears the state.
        write_reg(alrc_pkg::REG_RATE_OFF, 10'h001);
        finish_writes();
        queue_tick(16'd960, 1'b0, 1'b1);
        queue_tick(16'h0001, 1'b0, 1'b1);
        wait_drained();

        // A long run under the target and then a longer one over it, so the integrator
        // climbs and then falls well below zero, with both sides running flat out.
        write_reg(alrc_pkg::REG_RATE_OFF, '0);
        write_reg(alrc_pkg::REG_TARGET, alrc_pkg::TARGET_RESET);
        finish_writes();
        send_steady = 1'b1;
        take_steady = 1'b1;
        repeat (80) queue_tick(alrc_pkg::latency_t'($urandom_range(1, 900)), 1'b0, 1'b1);
        repeat (160) queue_tick(alrc_pkg::latency_t'($urandom_range(1100, 65535)), 1'b0, 1'b1);
        wait_drained();

        // Random phases, each with its own settings and its own idling pattern. Most
        // ticks are well formed around the target; the rest are noise.
        for (int phase = 0; phase < 6; phase++)
        begin
            pick = $urandom_range(0, 5);
            data = (pick == 0) ? '0 : (pick == 1) ? '1
                 : alrc_pkg::CFG_DATA_W'($urandom_range(0, 1023));
            write_reg(alrc_pkg::REG_TARGET, data);
            data = alrc_pkg::CFG_DATA_W'($urandom_range(0, 1023));
            data[0] = ($urandom_range(0, 4) == 0);
            write_reg(alrc_pkg::REG_RATE_OFF, data);
            write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
                      alrc_pkg::CFG_DATA_W'($urandom_range(0, 1023)));
            finish_writes();
            send_steady = ($urandom_range(0, 3) == 0);
            take_steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 125; i++)
            begin
                // Part way through the first phase the sender holds back until every
                // outstanding result has been delivered.
                if (phase == 0 && i == 62)
                begin
                    wait_drained();
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    queue_noise_tick();
                end
                else
                begin
                    queue_shaped_tick();
                end
            end
            wait_drained();
        end

        // Give the pipeline time to show any stray result before the verdict.
        repeat (6) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
